FILE: sv/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types and constants for the LIFO stack with search.
// ----------------------------------------------------------------------------
`default_nettype none

package lss_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = 7;
  localparam int WORD_W = 32;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_DRAIN  = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_SEARCH
  } state_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    word_t wdata;
    logic  re;
    addr_t raddr;
  } ram_req_t;

  typedef struct packed {
    logic    valid;
    word_t   value;
    logic    found;
    cnt_t    count;
    status_t status;
    logic    last;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/lifo_stack_with_search_top.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_search_top
// Bounded LIFO stack of 32-bit signed words with drain and search.
// ----------------------------------------------------------------------------
// Usage:
//   Issue a transaction by raising start with in_action and in_value_in while
//   busy is low. Results appear one cycle per strobe on out_valid; out_last
//   marks the final result of a transaction.
//   Push and the unused action code leave busy low, so a new transaction
//   may follow in the next cycle; the result shows in the cycle after the
//   accept.
//   Drain of N entries reads the stack RAM one entry a cycle through its
//   registered read port: busy until the stack is empty, results on
//   consecutive cycles, each through the RAM read and output registers.
//   Search walks the entries from the bottom through one shared compare,
//   one entry a cycle, and stops at the first match or at the top entry;
//   one result follows when it ends. Drain or search of an empty stack
//   answers without raising busy.
//   Reset empties the stack; RAM contents are not cleared.
//   The receiver cannot stall: each result stands for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lifo_stack_with_search_top
  import lss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_action,
  input  wire logic signed [WORD_W-1:0] in_value_in,
  output logic             out_valid,
  output logic signed [WORD_W-1:0] out_value_out,
  output logic             out_found,
  output logic [CNT_W-1:0] out_count,
  output logic             out_is_empty,
  output logic [1:0]       out_status,
  output logic             out_last
);

  ram_req_t ram_req;
  result_t  res;
  word_t    rd_data;
  logic     valid_r;
  result_t  res_r;

  lss_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .action   (in_action),
    .value_in (in_value_in),
    .rd_data  (rd_data),
    .busy     (busy),
    .ram_req  (ram_req),
    .res      (res)
  );

  lss_ram #(
    .DEPTH  (DEPTH),
    .DATA_W (WORD_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rd_data)
  );

  // register the result so it stands for one full cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res;
  end

  assign out_valid     = valid_r;
  assign out_value_out = res_r.value;
  assign out_found     = res_r.found;
  assign out_count     = res_r.count;
  assign out_is_empty  = (res_r.count == '0);
  assign out_status    = res_r.status;
  assign out_last      = res_r.last;

endmodule

`default_nettype wire

FILE: sv/lss_ram.sv
// ----------------------------------------------------------------------------
// lss_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module lss_ram #(
  parameter int DEPTH  = 64,
  parameter int DATA_W = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/lss_seq.sv
// ----------------------------------------------------------------------------
// lss_seq
// Sequencer for push, drain and search; walks the stack RAM one entry a
// cycle through a single shared equality compare.
// ----------------------------------------------------------------------------
`default_nettype none

module lss_seq
  import lss_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  wire logic [1:0] action,
  input  wire word_t   value_in,
  input  wire word_t   rd_data,
  output logic         busy,
  output ram_req_t     ram_req,
  output result_t      res
);

  state_t state_r, state_nxt;
  cnt_t   count_r, count_nxt;
  addr_t  ptr_r, ptr_nxt;
  word_t  key_r, key_nxt;
  word_t  top_r, top_nxt;

  logic   hit;
  logic   srch_done;
  logic   full;
  logic   empty;

  assign busy  = (state_r != ST_IDLE);
  assign full  = (count_r == cnt_t'(DEPTH));
  assign empty = (count_r == '0);

  // shared compare unit
  assign hit       = (rd_data == key_r);
  assign srch_done = hit || ((cnt_t'(ptr_r) + cnt_t'(1)) == count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      top_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      top_r   <= top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    key_r <= key_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (action)
            ACT_DRAIN:  if (!empty) state_nxt = ST_DRAIN;
            ACT_SEARCH: if (!empty) state_nxt = ST_SEARCH;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_DRAIN: begin
        if (empty) state_nxt = ST_IDLE;
      end
      ST_SEARCH: begin
        if (srch_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    key_nxt       = key_r;
    top_nxt       = top_r;
    ram_req       = '0;
    ram_req.waddr = count_r[ADDR_W-1:0];
    ram_req.wdata = value_in;
    res           = '0;
    res.value     = top_r;
    res.count     = count_r;
    res.status    = STAT_OK;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (action)
            ACT_PUSH: begin
              res.valid = 1'b1;
              res.last  = 1'b1;
              if (full) begin
                res.status = STAT_FULL;
              end else begin
                ram_req.we = 1'b1;
                count_nxt  = count_r + cnt_t'(1);
                top_nxt    = value_in;
                res.count  = count_r + cnt_t'(1);
                res.value  = value_in;
              end
            end
            ACT_DRAIN: begin
              if (empty) begin
                res.valid  = 1'b1;
                res.last   = 1'b1;
                res.status = STAT_EMPTY;
                res.value  = '0;
              end else begin
                // issue read of the top entry and pop it
                ram_req.re    = 1'b1;
                ram_req.raddr = addr_t'(count_r - cnt_t'(1));
                count_nxt     = count_r - cnt_t'(1);
              end
            end
            ACT_SEARCH: begin
              key_nxt = value_in;
              if (empty) begin
                res.valid = 1'b1;
                res.last  = 1'b1;
              end else begin
                ram_req.re    = 1'b1;
                ram_req.raddr = '0;
                ptr_nxt       = '0;
              end
            end
            default: begin
              res.valid = 1'b1;
              res.last  = 1'b1;
            end
          endcase
        end
      end
      ST_DRAIN: begin
        // data for the entry popped last cycle is on rd_data
        res.valid = 1'b1;
        res.value = rd_data;
        res.last  = empty;
        if (empty) begin
          top_nxt = '0;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = addr_t'(count_r - cnt_t'(1));
          count_nxt     = count_r - cnt_t'(1);
        end
      end
      ST_SEARCH: begin
        if (srch_done) begin
          res.valid = 1'b1;
          res.last  = 1'b1;
          res.found = hit;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = ptr_r + addr_t'(1);
          ptr_nxt       = ptr_r + addr_t'(1);
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

`default_nettype wire
